// ===== rtl/sepm_pkg.sv =====
// ----------------------------------------------------------------------------
// sepm_pkg
// Shared types and constants for the SHA-1 entropy pool mixer: request and
// response payloads, controller/datapath interface and SHA-1 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sepm_pkg;

   // Pool geometry
   localparam int POOL_BYTES = 20;
   localparam int POOL_BITS  = POOL_BYTES * 8;
   localparam int POOL_WORDS = POOL_BYTES / 4;

   // Request modes (mode 3 acts as generate)
   localparam logic [1:0] MODE_GENERATE = 2'd0;
   localparam logic [1:0] MODE_SEED     = 2'd1;
   localparam logic [1:0] MODE_MIX      = 2'd2;

   // Round sequencing: four phases of twenty rounds
   localparam logic [1:0] PHASE_LAST = 2'd3;
   localparam logic [4:0] STEP_LAST  = 5'd19;

   // Message schedule window
   localparam int SCHED_WORDS = 16;

   // SHA-1 constants
   localparam logic [31:0] ROUND_K [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };
   localparam logic [31:0] INIT_H [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   // Padding words of a single 160-bit message
   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [31:0] LEN_WORD = 32'd160;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] entropy_first;
      logic [7:0] entropy_second;
      logic [4:0] seed_index;
      logic       request_end;
   } sepm_req_type;

   typedef struct packed {
      logic [7:0] random_byte;
      logic       request_end_out;
   } sepm_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_DELIVER
   } sepm_state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       round;
      logic [1:0] phase;
      logic       finish;
      logic       deliver;
   } sepm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } sepm_status_type;

   // Round function selected by phase
   function automatic logic [31:0] round_f(input logic [1:0] phase,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      logic [31:0] f;
      case (phase)
         2'd0: begin
            f = (b & c) | (~b & d);
         end
         2'd2: begin
            f = (b & c) | (b & d) | (c & d);
         end
         default: begin
            f = b ^ c ^ d;
         end
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sepm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sepm_ctrl
// Sequencer for the mixer: takes a request, steps the 80 SHA-1 rounds and
// hands the finished byte to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module sepm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire sepm_pkg::sepm_status_type status,
   output sepm_pkg::sepm_cmd_type         cmd
);

   sepm_pkg::sepm_state_type state_ff, state_in;
   logic [1:0]               phase_ff, phase_in;
   logic [4:0]               step_ff, step_in;

   // State and round counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sepm_pkg::ST_IDLE;
         phase_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.phase   = phase_ff;
      req_stall   = 1'b1;
      case (state_ff)
         sepm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               phase_in = '0;
               step_in  = '0;
               state_in = sepm_pkg::ST_ROUND;
            end
         end
         sepm_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (step_ff == sepm_pkg::STEP_LAST) begin
               step_in = '0;
               if (phase_ff == sepm_pkg::PHASE_LAST) begin
                  state_in = sepm_pkg::ST_FINISH;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         sepm_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            if (!status.rsp_busy) begin
               cmd.deliver = 1'b1;
               state_in    = sepm_pkg::ST_IDLE;
            end else begin
               state_in = sepm_pkg::ST_DELIVER;
            end
         end
         sepm_pkg::ST_DELIVER: begin
            if (!status.rsp_busy) begin
               cmd.deliver = 1'b1;
               state_in    = sepm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sepm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sepm_datapath.sv =====
// ----------------------------------------------------------------------------
// sepm_datapath
// Pool register, SHA-1 round unit with rolling message schedule, digest
// write-back and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module sepm_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sepm_pkg::sepm_cmd_type cmd,
   output sepm_pkg::sepm_status_type   status,
   input  wire sepm_pkg::sepm_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sepm_pkg::sepm_rsp_type      rsp_data
);

   localparam int PB = sepm_pkg::POOL_BITS;

   // Pool and per-request context
   logic [PB-1:0] pool_ff;
   logic [1:0]    mode_ff;
   logic [4:0]    index_ff;
   logic          end_ff;
   logic [7:0]    byte_hold_ff;

   // Working variables and schedule window
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] w_ff [sepm_pkg::SCHED_WORDS];

   // Response register
   logic                   rsp_valid_ff;
   sepm_pkg::sepm_rsp_type rsp_data_ff;

   logic [PB-1:0] pool_ins;
   logic [PB-1:0] pool_new;
   logic [31:0]   temp;
   logic [31:0]   w_next;
   logic [31:0]   h0;
   logic [7:0]    byte_new;

   // Entropy insertion (not in mix mode): second byte to the front, first byte to the back
   always_comb begin
      pool_ins = pool_ff;
      if (req_data.mode != sepm_pkg::MODE_MIX) begin
         pool_ins[PB-1 -: 8] = req_data.entropy_second;
         pool_ins[7:0]       = req_data.entropy_first;
      end
   end

   // One SHA-1 round and the next schedule word
   always_comb begin
      temp = {a_ff[26:0], a_ff[31:27]}
           + sepm_pkg::round_f(cmd.phase, b_ff, c_ff, d_ff)
           + e_ff + sepm_pkg::ROUND_K[cmd.phase] + w_ff[0];
      w_next = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_next = {w_next[30:0], w_next[31]};
   end

   // Digest and seeding write-back
   always_comb begin
      h0       = sepm_pkg::INIT_H[0] + a_ff;
      byte_new = h0[31:24];
      pool_new = {h0,
                  sepm_pkg::INIT_H[1] + b_ff,
                  sepm_pkg::INIT_H[2] + c_ff,
                  sepm_pkg::INIT_H[3] + d_ff,
                  sepm_pkg::INIT_H[4] + e_ff};
      if (mode_ff == sepm_pkg::MODE_SEED) begin
         for (int k = 0; k < sepm_pkg::POOL_BYTES; k++) begin
            if (index_ff == 5'(k)) begin
               pool_new[PB-1-8*k -: 8] = byte_new;
            end
         end
      end
   end

   // Pool holds architectural state and clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= '0;
      end else if (cmd.load) begin
         pool_ff <= pool_ins;
      end else if (cmd.finish) begin
         pool_ff <= pool_new;
      end
   end

   // Round engine
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_data.mode;
         index_ff <= req_data.seed_index;
         end_ff   <= req_data.request_end;
         a_ff     <= sepm_pkg::INIT_H[0];
         b_ff     <= sepm_pkg::INIT_H[1];
         c_ff     <= sepm_pkg::INIT_H[2];
         d_ff     <= sepm_pkg::INIT_H[3];
         e_ff     <= sepm_pkg::INIT_H[4];
         for (int k = 0; k < sepm_pkg::SCHED_WORDS; k++) begin
            if (k < sepm_pkg::POOL_WORDS) begin
               w_ff[k] <= pool_ins[PB-1-32*k -: 32];
            end else if (k == sepm_pkg::POOL_WORDS) begin
               w_ff[k] <= sepm_pkg::PAD_WORD;
            end else if (k == sepm_pkg::SCHED_WORDS - 1) begin
               w_ff[k] <= sepm_pkg::LEN_WORD;
            end else begin
               w_ff[k] <= '0;
            end
         end
      end else if (cmd.round) begin
         a_ff <= temp;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
         for (int k = 0; k < sepm_pkg::SCHED_WORDS - 1; k++) begin
            w_ff[k] <= w_ff[k+1];
         end
         w_ff[sepm_pkg::SCHED_WORDS-1] <= w_next;
      end
      if (cmd.finish) begin
         byte_hold_ff <= byte_new;
      end
   end

   // Response register; a held response blocks delivery
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_data_ff.random_byte     <= cmd.finish ? byte_new : byte_hold_ff;
         rsp_data_ff.request_end_out <= end_ff;
      end
   end

   assign status.rsp_busy = rsp_valid_ff & rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sha1_entropy_pool_mixer.sv =====
// Flow: an accepted request runs the 80 SHA-1 rounds on a single round unit,
//   then the digest is written back and, if the response register is free,
//   loaded into it in the same cycle. No new request is taken until the result is in the response register.
// A stalled response holds the next result back until it is taken.
// Reset (synchronous, active high) clears the 20-byte pool to zero and
//   empties the response register.
// ----------------------------------------------------------------------------
// sha1_entropy_pool_mixer
// Entropy pool mixer: inserts two entropy bytes per request (not in mix mode),
// rehashes the pool with SHA-1 and returns the first digest byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_entropy_pool_mixer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sepm_pkg::sepm_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sepm_pkg::sepm_rsp_type      rsp_data
);

   sepm_pkg::sepm_cmd_type    cmd;
   sepm_pkg::sepm_status_type status;

   // Sequencer
   sepm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Pool, round unit and response register
   sepm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A request is loaded only on an accepting edge
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && !req_stall))
      else $error("load without accepted request");

   // Delivery never overwrites a stalled response
   assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> !(rsp_valid && rsp_stall))
      else $error("response overwritten while stalled");

   // The block is busy once a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a request while working");

   // Rounds and finish never coincide with a load
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(cmd.round || cmd.finish))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// ===== sim/sepm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sepm_checker
// Watches both channels of the entropy pool mixer. Keeps its own copy of the
// 20-byte pool, rehashes it with a behavioral SHA-1 on every accepted
// request and compares each response with the oldest predicted byte.
// ----------------------------------------------------------------------------

module sepm_checker
   import sepm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire sepm_req_type req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire sepm_rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending_count
);

   // SHA-1 initial chaining value, h0 in the top word
   localparam logic [159:0] DIGEST_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   logic [POOL_BITS-1:0] pool_image;
   logic [POOL_BITS-1:0] mixed_pool;
   sepm_rsp_type         pending_bytes [$];
   sepm_rsp_type         predicted;
   sepm_rsp_type         oldest;
   int                   fail_total = 0;

   assign mismatch_count = fail_total;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Digest of the pool taken as one 160-bit message in a single padded block
   function automatic logic [POOL_BITS-1:0] sha1_digest(input logic [POOL_BITS-1:0] msg);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = 32'h0;
      for (int i = 0; i < POOL_WORDS; i++) w[i] = msg[POOL_BITS - 1 - 32 * i -: 32];
      w[POOL_WORDS] = 32'h8000_0000;   // pad bit right after the message
      w[15]         = 32'(POOL_BITS);  // message length in bits
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      {a, b, c, d, e} = DIGEST_IV;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      return {DIGEST_IV[159:128] + a, DIGEST_IV[127:96] + b, DIGEST_IV[95:64] + c,
              DIGEST_IV[63:32] + d, DIGEST_IV[31:0] + e};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pool_image = '0;
         pending_bytes.delete();
      end else begin
         // response side: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected response, expected none, got byte %02h end %b",
                        $time, rsp_data.random_byte, rsp_data.request_end_out);
               fail_total++;
            end else begin
               oldest = pending_bytes.pop_front();
               if (rsp_data.random_byte !== oldest.random_byte) begin
                  $display("%0t: random_byte mismatch, expected %02h, got %02h",
                           $time, oldest.random_byte, rsp_data.random_byte);
                  fail_total++;
               end
               if (rsp_data.request_end_out !== oldest.request_end_out) begin
                  $display("%0t: request_end_out mismatch, expected %b, got %b",
                           $time, oldest.request_end_out, rsp_data.request_end_out);
                  fail_total++;
               end
            end
         end

         // request side: insert entropy, rehash, optional write-back
         if (req_valid && !req_stall) begin
            mixed_pool = pool_image;
            // mix-only leaves the entropy bytes out
            if (req_data.mode != MODE_MIX) begin
               mixed_pool[7:0]                = req_data.entropy_first;
               mixed_pool[POOL_BITS - 1 -: 8] = req_data.entropy_second;
            end
            mixed_pool = sha1_digest(mixed_pool);
            // seeding copies the output byte back; out-of-range index skips it
            if (req_data.mode == MODE_SEED && req_data.seed_index < POOL_BYTES)
               mixed_pool[POOL_BITS - 1 - 8 * req_data.seed_index -: 8] =
                  mixed_pool[POOL_BITS - 1 -: 8];
            pool_image                = mixed_pool;
            predicted.random_byte     = mixed_pool[POOL_BITS - 1 -: 8];
            predicted.request_end_out = req_data.request_end;
            pending_bytes.push_back(predicted);
         end
      end
      pending_count = pending_bytes.size();
   end

endmodule

// ===== sim/tb_sha1_entropy_pool_mixer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_entropy_pool_mixer
// Drives directed and random requests into the entropy pool mixer with random
// sender gaps and response backpressure; the checker predicts every byte.
// ----------------------------------------------------------------------------

module tb_sha1_entropy_pool_mixer;
   import sepm_pkg::*;

   localparam int         RANDOM_REQUESTS = 600;
   localparam int         CYCLE_LIMIT     = 1_500_000;
   localparam int         DRAIN_CYCLES    = 100;
   localparam logic [1:0] MODE_SPARE      = 2'd3;   // unused code, acts as generate

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   sepm_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   sepm_rsp_type rsp_data;
   int           fail_count;
   int           pending_count;
   int           cycle_count = 0;
   int           stall_left  = 0;
   int           sent        = 0;
   bit           quiet_sender = 1'b0;

   sha1_entropy_pool_mixer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sepm_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (fail_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Length of the next stall or release run; long releases give quiet stretches
   function automatic int pick_run(input logic stalling);
      int roll;
      roll = $urandom_range(0, 99);
      if (stalling) begin
         if (roll < 90) return $urandom_range(0, 4);
         return $urandom_range(30, 150);
      end
      if (roll < 75) return $urandom_range(0, 6);
      return $urandom_range(100, 400);
   endfunction

   // Response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= ~rsp_stall;
         stall_left <= pick_run(~rsp_stall);
      end
   end

   // Idle cycles after a request: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_sender || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Present one request at a falling edge and hold it until accepted
   task automatic send_request(input logic [1:0] mode, input logic [7:0] first,
                               input logic [7:0] second, input logic [4:0] index,
                               input logic last);
      int gap;
      req_data  <= '{mode, first, second, index, last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      int         target;
      int         roll;
      int         run_len;
      int         seed_pos;
      logic [1:0] run_mode;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero pool, field extremes, every mode and index corner
      send_request(MODE_GENERATE, 8'h00, 8'h00, 5'd0,  1'b0);
      send_request(MODE_GENERATE, 8'hFF, 8'hFF, 5'd31, 1'b1);
      send_request(MODE_SEED,     8'h00, 8'hFF, 5'd0,  1'b0);  // index zero
      send_request(MODE_SEED,     8'hFF, 8'h00, 5'd19, 1'b1);  // last pool byte
      send_request(MODE_SEED,     8'h5A, 8'hA5, 5'd20, 1'b0);  // just out of range
      send_request(MODE_SEED,     8'h3C, 8'hC3, 5'd31, 1'b1);  // far out of range
      send_request(MODE_MIX,      8'hAA, 8'h55, 5'd7,  1'b0);  // entropy ignored
      send_request(MODE_MIX,      8'h00, 8'hFF, 5'd0,  1'b1);
      send_request(MODE_SPARE,    8'h12, 8'h34, 5'd3,  1'b0);
      send_request(MODE_SPARE,    8'hFF, 8'h00, 5'd0,  1'b1);
      send_request(MODE_GENERATE, 8'h80, 8'h01, 5'd0,  1'b0);
      send_request(MODE_SEED,     8'h01, 8'h80, 5'd1,  1'b0);
      send_request(MODE_SEED,     8'h7F, 8'hFE, 5'd2,  1'b0);
      send_request(MODE_SEED,     8'hFE, 8'h7F, 5'd4,  1'b0);
      send_request(MODE_SEED,     8'h0F, 8'hF0, 5'd8,  1'b0);
      send_request(MODE_SEED,     8'hF0, 8'h0F, 5'd16, 1'b1);
      send_request(MODE_SEED,     8'h00, 8'h00, 5'd10, 1'b1);
      send_request(MODE_MIX,      8'hFF, 8'hFF, 5'd31, 1'b0);
      send_request(MODE_GENERATE, 8'h00, 8'h00, 5'd0,  1'b1);

      // Random: mostly well-formed runs ending on request_end, some noise
      target = sent + RANDOM_REQUESTS;
      while (sent < target) begin
         quiet_sender = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         5'($urandom), 1'($urandom));
         end else begin
            run_len  = $urandom_range(1, 8);
            run_mode = (roll < 45) ? MODE_SEED : (roll < 85) ? MODE_GENERATE : MODE_MIX;
            seed_pos = $urandom_range(0, POOL_BYTES - 1);
            for (int i = 0; i < run_len; i++) begin
               send_request(run_mode, 8'($urandom), 8'($urandom),
                            5'((seed_pos + i) % POOL_BYTES), i == run_len - 1);
            end
         end
      end

      // Drain
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sepm_pkg.sv
rtl/sepm_ctrl.sv
rtl/sepm_datapath.sv
rtl/sha1_entropy_pool_mixer.sv
sim/sepm_checker.sv
sim/tb_sha1_entropy_pool_mixer.sv
